[src/seed_chain_overlap_trimmer_defines.svh]
// Assertion macros shared by the seed chain overlap trimmer RTL.
`ifndef SEED_CHAIN_OVERLAP_TRIMMER_DEFINES_SVH
`define SEED_CHAIN_OVERLAP_TRIMMER_DEFINES_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define SCOT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scot assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define SCOT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scot assertion failed");
`else
`define SCOT_ASSERT_IMP(label, ante, cons)
`define SCOT_ASSERT_NXT(label, ante, cons)
`endif
`endif

[src/scot_pkg.sv]
// Package with the item, entry, command and status types of the trimmer.
package scot_pkg;

  localparam int MAX_PAIRS_DEF = 64;
  localparam int QPOS_W        = 32;
  localparam int RPOS_W        = 36;
  localparam int LEN_W         = 20;

  typedef struct packed {
    logic [QPOS_W-1:0] query_pos;
    logic [RPOS_W-1:0] ref_pos;
    logic [LEN_W-1:0]  query_len;
    logic [LEN_W-1:0]  ref_len;
    logic              seed_flag;
    logic              last_in;
  } in_item_t;

  typedef struct packed {
    logic [QPOS_W-1:0] out_query_pos;
    logic [RPOS_W-1:0] out_ref_pos;
    logic [LEN_W-1:0]  out_query_len;
    logic [LEN_W-1:0]  out_ref_len;
    logic              out_seed_flag;
    logic              last_out;
    logic              none_left;
    logic              overflow;
  } out_item_t;

  // One stored fragment pair.
  typedef struct packed {
    logic [QPOS_W-1:0] qpos;
    logic [RPOS_W-1:0] rpos;
    logic [LEN_W-1:0]  qlen;
    logic [LEN_W-1:0]  rlen;
    logic              keep;
  } entry_t;

  // Strobes from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic idx_clr;
    logic idx_inc;
    logic rd_next;
    logic latch_a;
    logic cmp;
    logic trim_r;
    logic trim_q;
    logic cp_init;
    logic cp_wr;
    logic cp_end;
    logic em_none;
    logic em_load;
    logic chain_clr;
  } cmd_t;

  // Conditions from the datapath to the controller.
  typedef struct packed {
    logic cnt_lt2;
    logic cnt_zero;
    logic pair_more;
    logic idx_last;
    logic pass_drop;
    logic out_last;
  } stat_t;

endpackage

[src/scot_if.sv]
// Valid/ready channel interfaces for the trimmer's input and result streams.
interface scot_in_if import scot_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scot_out_if import scot_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/seed_chain_overlap_trimmer.sv]
// Top level of the seed chain overlap trimmer: controller, datapath and checks.
//
// Usage: a chain of fragment pairs arrives on in_ch, one request per cycle while
// in_ch.ready is high, in ascending query position, the final pair marked with
// last_in. Up to MAX_PAIRS pairs are stored; later pairs of the same chain are
// discarded and every result of that chain then carries overflow.
// After the final pair, the block stops taking requests and, if at least two
// pairs are stored, runs trim passes over them. A pass steps through adjacent
// pairs in the pair memory, each pair step reading the next pair, registering
// the differences and running the two trim stages. A pass that drops anything is
// followed by a compaction and another pass. When a pass drops nothing or no pass
// runs, the survivors leave on out_ch in order, each read only after the one before
// is taken; an empty outcome gives one result with none_left and last_out set.
// A stalled receiver holds the result register and the whole block; loading of
// the next chain starts in the cycle after the result with last_out is taken.
// Reset (synchronous, active high) empties the chain and returns to loading;
// the pair memory needs no clearing pass.
`include "seed_chain_overlap_trimmer_defines.svh"

module seed_chain_overlap_trimmer import scot_pkg::*; #(
  parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
  input logic        clk,
  input logic        rst,
  scot_in_if.sink    in_ch,
  scot_out_if.source out_ch
);

  cmd_t      cmd;
  stat_t     stat;
  out_item_t result;
  logic      in_ready;
  logic      out_valid;
  logic      last_taken;
  logic      none_shape;

  // The controller sequences load, pass, compaction and emit phases.
  scot_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.data.last_in),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // The datapath holds the pairs and does the overlap arithmetic.
  scot_dp #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_item  (in_ch.data),
    .stat     (stat),
    .out_item (result)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = result;

  // The final result of a chain is being taken.
  assign last_taken = out_ch.valid && out_ch.ready && out_ch.data.last_out;
  // The shape an empty outcome must have: last of its chain, zero lengths.
  assign none_shape = out_ch.data.last_out && (out_ch.data.out_query_len == '0) &&
                      (out_ch.data.out_ref_len == '0);

  // Loading and emitting never overlap.
  `SCOT_ASSERT_IMP(a_load_emit_apart, in_ch.ready, !out_ch.valid)
  // Taking the final result of a chain reopens the input in the next cycle.
  `SCOT_ASSERT_NXT(a_reopen_after_last, last_taken, in_ch.ready)
  // An empty outcome is the last result of its chain and carries zero lengths.
  `SCOT_ASSERT_IMP(a_none_is_last, out_ch.valid && out_ch.data.none_left, none_shape)

endmodule

[src/scot_dp.sv]
// Datapath of the trimmer: pair memory, counters, trim stages and result register.
module scot_dp import scot_pkg::*; #(
  parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  in_item_t  in_item,
  output stat_t     stat,
  output out_item_t out_item
);

  localparam int AW = $clog2(MAX_PAIRS);
  localparam int CW = $clog2(MAX_PAIRS + 1);

  entry_t mem [MAX_PAIRS];
  entry_t rdata;

  logic [CW-1:0] cnt;
  logic [CW-1:0] wptr;
  logic [AW-1:0] idx;
  logic          ovf;
  logic          drop_seen;

  entry_t            ent_a;
  entry_t            ent_b;
  logic              ref_after;
  logic [RPOS_W-1:0] gap_ref;
  logic [QPOS_W:0]   gap_qry;
  logic              drop_r;
  logic [LEN_W-1:0]  ql_r;
  logic [LEN_W-1:0]  rl_r;

  logic [RPOS_W:0]  ref_diff;
  logic [QPOS_W:0]  qry_diff;
  logic             ref_ovl;
  logic             q_ovl;
  logic [LEN_W-1:0] ovr;
  logic [LEN_W-1:0] ovq;
  logic [LEN_W-1:0] ql1;
  logic [LEN_W-1:0] rl1;
  logic [LEN_W-1:0] ql2;
  logic [LEN_W-1:0] rl2;
  logic             drop1;
  logic             drop2;
  entry_t           trim_wdata;

  logic          full;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  entry_t        wdata;
  logic [CW:0]   idx_p2;

  // Differences between an entry and its successor, registered before trimming.
  assign ref_diff = {1'b0, rdata.rpos} - {1'b0, ent_a.rpos};
  assign qry_diff = {1'b0, rdata.qpos} - {1'b0, ent_a.qpos};

  // Reference overlap trim.
  always_comb begin
    ovr     = ent_a.rlen - gap_ref[LEN_W-1:0];
    ref_ovl = (gap_ref[RPOS_W-1:LEN_W] == '0) && (gap_ref[LEN_W-1:0] < ent_a.rlen);
    drop1   = 1'b0;
    ql1     = ent_a.qlen;
    rl1     = ent_a.rlen;
    if (!ref_after) begin
      drop1 = 1'b1;
    end else if (ref_ovl) begin
      if (ent_a.qlen <= ovr) begin
        drop1 = 1'b1;
      end else begin
        ql1 = ent_a.qlen - ovr;
        rl1 = gap_ref[LEN_W-1:0];
      end
    end
  end

  // Query overlap trim; a negative query gap always drops the entry, a zero one unless the query length is zero.
  always_comb begin
    ovq   = ql_r - gap_qry[LEN_W-1:0];
    q_ovl = gap_qry[QPOS_W] ||
            ((gap_qry[QPOS_W-1:LEN_W] == '0) && (gap_qry[LEN_W-1:0] < ql_r));
    drop2 = drop_r;
    ql2   = ql_r;
    rl2   = rl_r;
    if (!drop_r && q_ovl) begin
      if (gap_qry[QPOS_W] || (gap_qry == '0)) begin
        drop2 = 1'b1;
      end else if (rl_r <= ovq) begin
        drop2 = 1'b1;
      end else begin
        ql2 = gap_qry[LEN_W-1:0];
        rl2 = rl_r - ovq;
      end
    end
    trim_wdata = ent_a;
    if (drop2) begin
      trim_wdata.keep = 1'b0;
    end else begin
      trim_wdata.qlen = ql2;
      trim_wdata.rlen = rl2;
    end
  end

  assign full = (cnt == CW'(MAX_PAIRS));

  always_comb begin
    mem_we     = 1'b0;
    waddr      = cnt[AW-1:0];
    wdata.qpos = in_item.query_pos;
    wdata.rpos = in_item.ref_pos;
    wdata.qlen = in_item.query_len;
    wdata.rlen = in_item.ref_len;
    wdata.keep = in_item.seed_flag;
    if (cmd.load) begin
      mem_we = !full;
    end else if (cmd.trim_q) begin
      mem_we = 1'b1;
      waddr  = idx;
      wdata  = trim_wdata;
    end else if (cmd.cp_wr) begin
      mem_we = rdata.keep;
      waddr  = wptr[AW-1:0];
      wdata  = rdata;
    end
  end

  assign raddr = cmd.rd_next ? (idx + AW'(1)) : idx;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign idx_p2         = (CW + 1)'(idx) + (CW + 1)'(2);
  assign stat.cnt_lt2   = (cnt < CW'(2));
  assign stat.cnt_zero  = (cnt == '0);
  assign stat.pair_more = (idx_p2 < {1'b0, cnt});
  assign stat.idx_last  = ((CW'(idx) + CW'(1)) == cnt);
  assign stat.pass_drop = drop_seen | drop2;
  assign stat.out_last  = out_item.last_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      ovf       <= 1'b0;
      idx       <= '0;
      wptr      <= '0;
      drop_seen <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          cnt <= cnt + CW'(1);
        end
      end
      if (cmd.cp_end) begin
        cnt <= wptr;
      end
      if (cmd.chain_clr) begin
        cnt <= '0;
        ovf <= 1'b0;
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + AW'(1);
      end
      if (cmd.cp_init) begin
        wptr <= '0;
      end else if (cmd.cp_wr && rdata.keep) begin
        wptr <= wptr + CW'(1);
      end
      if (cmd.latch_a) begin
        drop_seen <= 1'b0;
      end else if (cmd.trim_q) begin
        drop_seen <= drop_seen | drop2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_a) begin
      ent_a <= rdata;
    end else if (cmd.trim_q) begin
      ent_a <= ent_b;
    end
    if (cmd.cmp) begin
      ent_b     <= rdata;
      ref_after <= !ref_diff[RPOS_W] && (ref_diff[RPOS_W-1:0] != '0);
      gap_ref   <= ref_diff[RPOS_W-1:0];
      gap_qry   <= qry_diff;
    end
    if (cmd.trim_r) begin
      drop_r <= drop1;
      ql_r   <= ql1;
      rl_r   <= rl1;
    end
    if (cmd.em_none) begin
      out_item.out_query_pos <= '0;
      out_item.out_ref_pos   <= '0;
      out_item.out_query_len <= '0;
      out_item.out_ref_len   <= '0;
      out_item.out_seed_flag <= 1'b0;
      out_item.last_out      <= 1'b1;
      out_item.none_left     <= 1'b1;
      out_item.overflow      <= ovf;
    end else if (cmd.em_load) begin
      out_item.out_query_pos <= rdata.qpos;
      out_item.out_ref_pos   <= rdata.rpos;
      out_item.out_query_len <= rdata.qlen;
      out_item.out_ref_len   <= rdata.rlen;
      out_item.out_seed_flag <= rdata.keep;
      out_item.last_out      <= stat.idx_last;
      out_item.none_left     <= 1'b0;
      out_item.overflow      <= ovf;
    end
  end

endmodule

[src/scot_ctrl.sv]
// Controller state machine of the trimmer: load, trim passes, compaction, emit.
module scot_ctrl import scot_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_last,
  input  logic  out_ready,
  input  stat_t stat,
  output logic  in_ready,
  output logic  out_valid,
  output cmd_t  cmd
);

  typedef enum logic [14:0] {
    S_LOAD   = 15'b000000000000001,
    S_PINIT  = 15'b000000000000010,
    S_PLATCH = 15'b000000000000100,
    S_RD     = 15'b000000000001000,
    S_CMP    = 15'b000000000010000,
    S_TRIMR  = 15'b000000000100000,
    S_TRIMQ  = 15'b000000001000000,
    S_CINIT  = 15'b000000010000000,
    S_CRD    = 15'b000000100000000,
    S_CWR    = 15'b000001000000000,
    S_CEND   = 15'b000010000000000,
    S_EINIT  = 15'b000100000000000,
    S_ERD    = 15'b001000000000000,
    S_ELOAD  = 15'b010000000000000,
    S_EWAIT  = 15'b100000000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_LOAD: begin
        in_ready    = 1'b1;
        cmd.idx_clr = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_next = S_PINIT;
          end
        end
      end
      S_PINIT: begin
        if (stat.cnt_lt2) begin
          state_next = S_EINIT;
        end else begin
          state_next = S_PLATCH;
        end
      end
      S_PLATCH: begin
        cmd.latch_a = 1'b1;
        state_next  = S_RD;
      end
      S_RD: begin
        cmd.rd_next = 1'b1;
        state_next  = S_CMP;
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = S_TRIMR;
      end
      S_TRIMR: begin
        cmd.trim_r = 1'b1;
        state_next = S_TRIMQ;
      end
      S_TRIMQ: begin
        cmd.trim_q  = 1'b1;
        cmd.idx_inc = 1'b1;
        if (stat.pair_more) begin
          state_next = S_RD;
        end else if (stat.pass_drop) begin
          state_next = S_CINIT;
        end else begin
          state_next = S_EINIT;
        end
      end
      S_CINIT: begin
        cmd.cp_init = 1'b1;
        cmd.idx_clr = 1'b1;
        state_next  = S_CRD;
      end
      S_CRD: begin
        state_next = S_CWR;
      end
      S_CWR: begin
        cmd.cp_wr   = 1'b1;
        cmd.idx_inc = 1'b1;
        if (stat.idx_last) begin
          state_next = S_CEND;
        end else begin
          state_next = S_CRD;
        end
      end
      S_CEND: begin
        cmd.cp_end  = 1'b1;
        cmd.idx_clr = 1'b1;
        state_next  = S_PINIT;
      end
      S_EINIT: begin
        cmd.idx_clr = 1'b1;
        if (stat.cnt_zero) begin
          cmd.em_none = 1'b1;
          state_next  = S_EWAIT;
        end else begin
          state_next = S_ERD;
        end
      end
      S_ERD: begin
        state_next = S_ELOAD;
      end
      S_ELOAD: begin
        cmd.em_load = 1'b1;
        state_next  = S_EWAIT;
      end
      S_EWAIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.out_last) begin
            cmd.chain_clr = 1'b1;
            state_next    = S_LOAD;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_ERD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule
